[rtl/core/cmep_pkg.sv]
// Shared types and constants for the compact MIDI event parser.
`timescale 1ns / 1ps

package cmep_pkg;

    localparam int TIME_WIDTH_DEF   = 32;
    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH      = 4;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int CHAN_W   = 4;
    localparam int FIELD_W  = 7;
    localparam int TEMPO_W  = 24;
    localparam int OUT_W    = 32;
    localparam int LEN_W    = 4;

    // Event kind codes
    localparam logic [KIND_W-1:0] K_ON        = 4'd0;
    localparam logic [KIND_W-1:0] K_OFF       = 4'd1;
    localparam logic [KIND_W-1:0] K_MOD       = 4'd2;
    localparam logic [KIND_W-1:0] K_BREATH    = 4'd3;
    localparam logic [KIND_W-1:0] K_LOOPNUM   = 4'd4;
    localparam logic [KIND_W-1:0] K_VOL       = 4'd5;
    localparam logic [KIND_W-1:0] K_PAN       = 4'd6;
    localparam logic [KIND_W-1:0] K_EXPR      = 4'd7;
    localparam logic [KIND_W-1:0] K_LOOPCNT   = 4'd8;
    localparam logic [KIND_W-1:0] K_LOOPSTART = 4'd9;
    localparam logic [KIND_W-1:0] K_LOOPEND   = 4'd10;
    localparam logic [KIND_W-1:0] K_PROG      = 4'd11;
    localparam logic [KIND_W-1:0] K_BEND      = 4'd12;
    localparam logic [KIND_W-1:0] K_TEMPO     = 4'd13;
    localparam logic [KIND_W-1:0] K_END       = 4'd14;
    localparam logic [KIND_W-1:0] K_UNKNOWN   = 4'd15;

    // Event record handed from the parser to the output side.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  chan;
        logic [FIELD_W-1:0] first_field;
        logic [FIELD_W-1:0] second_field;
        logic [TEMPO_W-1:0] tempo_value;
        logic [OUT_W-1:0]   tick_time;
        logic [OUT_W-1:0]   event_offset;
        logic [LEN_W-1:0]   end_low;
    } event_rec_t;

endpackage

[rtl/core/compact_midi_event_parser.sv]
// Top level of the compact MIDI event parser: parser, event queue, output side.
//
//   channel   direction   handshake           payload
//   input     in          push / full         byte_in
//   result    out         empty / pop         event_kind .. event_length
//
// One byte per cycle while full is low; the parser settles each byte in the cycle it is taken.
// A result appears in the cycle after its last byte is taken and waits in a four-entry queue.
// full rises only when the queue holds four results nobody has popped.
// Reset clears parser state and empties the queue; after an end or unknown
// event the parser drops every byte until reset.
`timescale 1ns / 1ps

module compact_midi_event_parser #(
    parameter int TIME_WIDTH   = cmep_pkg::TIME_WIDTH_DEF,
    parameter int OFFSET_WIDTH = cmep_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [cmep_pkg::BYTE_W-1:0]         byte_in,
    output logic                                empty,
    input  logic                                pop,
    output logic [cmep_pkg::KIND_W-1:0]         event_kind,
    output logic [cmep_pkg::CHAN_W-1:0]         chan,
    output logic [cmep_pkg::FIELD_W-1:0]        first_field,
    output logic [cmep_pkg::FIELD_W-1:0]        second_field,
    output logic [cmep_pkg::TEMPO_W-1:0]        tempo_value,
    output logic [cmep_pkg::OUT_W-1:0]          tick_time,
    output logic [cmep_pkg::OUT_W-1:0]          event_offset,
    output logic [cmep_pkg::LEN_W-1:0]          event_length
);

    logic                 take;
    logic                 rec_valid;
    cmep_pkg::event_rec_t rec_in;
    cmep_pkg::event_rec_t rec_out;

    assign take = push && !full;

    cmep_front #(
        .TIME_WIDTH   (TIME_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (byte_in),
        .rec_valid (rec_valid),
        .rec       (rec_in)
    );

    cmep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (rec_in),
        .rd_en   (pop),
        .rd_data (rec_out),
        .full    (full),
        .empty   (empty)
    );

    cmep_back u_back (
        .rec          (rec_out),
        .event_kind   (event_kind),
        .chan         (chan),
        .first_field  (first_field),
        .second_field (second_field),
        .tempo_value  (tempo_value),
        .tick_time    (tick_time),
        .event_offset (event_offset),
        .event_length (event_length)
    );

endmodule

[rtl/core/cmep_front.sv]
// Byte parser: tracks delta time, running status and event fields, builds records.
`timescale 1ns / 1ps

module cmep_front #(
    parameter int TIME_WIDTH   = cmep_pkg::TIME_WIDTH_DEF,
    parameter int OFFSET_WIDTH = cmep_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [7:0]               byte_in,
    output logic                     rec_valid,
    output cmep_pkg::event_rec_t     rec
);

    localparam logic [2:0] PH_DELTA  = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_DATA1  = 3'd2;
    localparam logic [2:0] PH_DATA2  = 3'd3;
    localparam logic [2:0] PH_META   = 3'd4;
    localparam logic [2:0] PH_TEMPO  = 3'd5;

    localparam logic [3:0] HI_OFF  = 4'h8;
    localparam logic [3:0] HI_ON   = 4'h9;
    localparam logic [3:0] HI_CTRL = 4'hB;
    localparam logic [3:0] HI_PROG = 4'hC;
    localparam logic [3:0] HI_BEND = 4'hE;
    localparam logic [3:0] HI_SYS  = 4'hF;
    localparam logic [7:0] ST_META = 8'hFF;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_EOT   = 8'h2F;

    logic [2:0]              phase_reg, phase_next;
    logic [7:0]              rs_reg, rs_next;
    logic                    skip_reg, skip_next;
    logic [27:0]             dacc_reg, dacc_next;
    logic [2:0]              dbytes_reg, dbytes_next;
    logic [TIME_WIDTH-1:0]   abs_reg, abs_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [7:0]              cur_reg, cur_next;
    logic [6:0]              held_reg, held_next;
    logic                    held_hi_reg, held_hi_next;
    logic [23:0]             tempo_reg, tempo_next;
    logic [2:0]              mcount_reg, mcount_next;
    logic                    halted_reg, halted_next;

    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic                    reused;
    logic [7:0]              st;
    logic                    do_data1;
    logic                    do_delta;
    logic                    do_finish;
    logic                    fin_skip;
    logic [27:0]             dacc_shift;
    logic [2:0]              dbytes_inc;
    logic [23:0]             tempo_shift;
    logic [2:0]              mcount_inc;
    logic [OFFSET_WIDTH-1:0] end_pos;
    logic [31:0]             tick32;
    logic [31:0]             start32;

    generate
        if (TIME_WIDTH >= 32) begin : g_tick_trunc
            assign tick32 = abs_reg[31:0];
        end else begin : g_tick_ext
            assign tick32 = {{(32-TIME_WIDTH){1'b0}}, abs_reg};
        end
        if (OFFSET_WIDTH >= 32) begin : g_off_trunc
            assign start32 = start_reg[31:0];
        end else begin : g_off_ext
            assign start32 = {{(32-OFFSET_WIDTH){1'b0}}, start_reg};
        end
    endgenerate

    assign pos_inc     = pos_reg + OFFSET_WIDTH'(1);
    assign dacc_shift  = {dacc_reg[20:0], byte_in[6:0]};
    assign dbytes_inc  = dbytes_reg + 3'd1;
    assign tempo_shift = {tempo_reg[15:0], byte_in};
    assign mcount_inc  = mcount_reg + 3'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        rs_next      = rs_reg;
        skip_next    = skip_reg;
        dacc_next    = dacc_reg;
        dbytes_next  = dbytes_reg;
        abs_next     = abs_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        cur_next     = cur_reg;
        held_next    = held_reg;
        held_hi_next = held_hi_reg;
        tempo_next   = tempo_reg;
        mcount_next  = mcount_reg;
        halted_next  = halted_reg;
        reused       = ~byte_in[7];
        st           = reused ? rs_reg : byte_in;
        do_data1     = 1'b0;
        do_delta     = 1'b0;
        do_finish    = 1'b0;
        fin_skip     = 1'b0;
        end_pos      = pos_inc;
        rec_valid    = 1'b0;
        rec          = '0;

        if (take && !halted_reg)
        begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_STATUS:
                begin
                    skip_next = 1'b0;
                    if (!reused && byte_in != ST_META)
                    begin
                        rs_next = byte_in;
                    end
                    cur_next = st;
                    if (st[7:4] inside {HI_OFF, HI_ON, HI_CTRL, HI_PROG, HI_BEND})
                    begin
                        phase_next = PH_DATA1;
                        do_data1   = reused;
                    end
                    else if (st[7:4] == HI_SYS)
                    begin
                        if (st == ST_META)
                        begin
                            phase_next = PH_META;
                        end
                        else if (reused)
                        begin
                            // system status under running status: byte restarts as delta
                            start_next = pos_reg;
                            do_delta   = 1'b1;
                        end
                        else
                        begin
                            do_finish = 1'b1;
                        end
                    end
                    else
                    begin
                        end_pos     = reused ? pos_reg : pos_inc;
                        rec_valid   = 1'b1;
                        rec.kind    = cmep_pkg::K_UNKNOWN;
                        halted_next = 1'b1;
                    end
                end
                PH_DATA1:
                begin
                    do_data1 = 1'b1;
                end
                PH_DATA2:
                begin
                    skip_next = byte_in[7];
                    fin_skip  = byte_in[7];
                    do_finish = 1'b1;
                    rec.first_field = held_reg;
                    if (cur_reg[7:4] == HI_ON)
                    begin
                        rec_valid = 1'b1;
                        if (byte_in[6:0] != 7'd0)
                        begin
                            rec.kind         = cmep_pkg::K_ON;
                            rec.second_field = byte_in[6:0];
                        end
                        else
                        begin
                            rec.kind = cmep_pkg::K_OFF;
                        end
                    end
                    else if (cur_reg[7:4] == HI_CTRL)
                    begin
                        rec.first_field = byte_in[6:0];
                        rec_valid       = !held_hi_reg;
                        case (held_reg)
                            7'd1:    rec.kind = cmep_pkg::K_MOD;
                            7'd2:    rec.kind = cmep_pkg::K_BREATH;
                            7'd6:    rec.kind = cmep_pkg::K_LOOPNUM;
                            7'd7:    rec.kind = cmep_pkg::K_VOL;
                            7'd10:   rec.kind = cmep_pkg::K_PAN;
                            7'd11:   rec.kind = cmep_pkg::K_EXPR;
                            7'd38:   rec.kind = cmep_pkg::K_LOOPCNT;
                            7'd99:
                            begin
                                if (byte_in[6:0] == 7'd0)
                                begin
                                    rec.kind = cmep_pkg::K_LOOPSTART;
                                end
                                else if (byte_in[6:0] == 7'd1)
                                begin
                                    rec.kind = cmep_pkg::K_LOOPEND;
                                end
                                else
                                begin
                                    rec_valid = 1'b0;
                                end
                            end
                            default: rec_valid = 1'b0;
                        endcase
                    end
                    else
                    begin
                        rec_valid        = 1'b1;
                        rec.kind         = cmep_pkg::K_BEND;
                        rec.second_field = byte_in[6:0];
                    end
                end
                PH_META:
                begin
                    if (byte_in == META_TEMPO)
                    begin
                        tempo_next  = '0;
                        mcount_next = '0;
                        phase_next  = PH_TEMPO;
                    end
                    else
                    begin
                        // non-tempo meta except EOT drops the type byte from the length
                        end_pos     = (byte_in == META_EOT) ? pos_inc : pos_reg;
                        rec_valid   = 1'b1;
                        rec.kind    = cmep_pkg::K_END;
                        halted_next = 1'b1;
                    end
                end
                PH_TEMPO:
                begin
                    tempo_next  = tempo_shift;
                    mcount_next = mcount_inc;
                    if (mcount_inc >= 3'd4)
                    begin
                        mcount_next     = '0;
                        rec_valid       = 1'b1;
                        rec.kind        = cmep_pkg::K_TEMPO;
                        rec.tempo_value = tempo_shift;
                        fin_skip        = skip_reg;
                        do_finish       = 1'b1;
                    end
                end
                default:
                begin
                    do_delta = 1'b1;
                end
            endcase

            if (do_data1)
            begin
                if (cur_next[7:4] == HI_OFF || cur_next[7:4] == HI_PROG)
                begin
                    skip_next       = byte_in[7];
                    fin_skip        = byte_in[7];
                    do_finish       = 1'b1;
                    rec_valid       = 1'b1;
                    rec.kind        = (cur_next[7:4] == HI_OFF) ? cmep_pkg::K_OFF
                                                                : cmep_pkg::K_PROG;
                    rec.first_field = byte_in[6:0];
                end
                else
                begin
                    held_next    = byte_in[6:0];
                    held_hi_next = byte_in[7];
                    phase_next   = PH_DATA2;
                end
            end

            if (do_delta)
            begin
                dacc_next   = dacc_shift;
                dbytes_next = dbytes_inc;
                phase_next  = PH_DELTA;
                // four bytes at most, whatever the continuation bit says
                if (!byte_in[7] || dbytes_inc >= 3'd4)
                begin
                    abs_next    = abs_reg + TIME_WIDTH'(dacc_shift);
                    dacc_next   = '0;
                    dbytes_next = '0;
                    phase_next  = PH_STATUS;
                end
            end

            if (do_finish)
            begin
                start_next = pos_inc;
                phase_next = fin_skip ? PH_STATUS : PH_DELTA;
            end

            rec.chan         = cur_next[3:0];
            rec.tick_time    = tick32;
            rec.event_offset = start32;
            rec.end_low      = end_pos[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DELTA;
            rs_reg      <= '0;
            skip_reg    <= 1'b0;
            dacc_reg    <= '0;
            dbytes_reg  <= '0;
            abs_reg     <= '0;
            pos_reg     <= '0;
            start_reg   <= '0;
            cur_reg     <= '0;
            held_reg    <= '0;
            held_hi_reg <= 1'b0;
            tempo_reg   <= '0;
            mcount_reg  <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rs_reg      <= rs_next;
            skip_reg    <= skip_next;
            dacc_reg    <= dacc_next;
            dbytes_reg  <= dbytes_next;
            abs_reg     <= abs_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            cur_reg     <= cur_next;
            held_reg    <= held_next;
            held_hi_reg <= held_hi_next;
            tempo_reg   <= tempo_next;
            mcount_reg  <= mcount_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

[rtl/core/cmep_queue.sv]
// Small event queue between the parser and the output side.
`timescale 1ns / 1ps

module cmep_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  cmep_pkg::event_rec_t wr_data,
    input  logic                 rd_en,
    output cmep_pkg::event_rec_t rd_data,
    output logic                 full,
    output logic                 empty
);

    localparam int DEPTH = cmep_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmep_pkg::event_rec_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/cmep_back.sv]
// Output side: turns a queued event record into the result fields.
`timescale 1ns / 1ps

module cmep_back (
    input  cmep_pkg::event_rec_t          rec,
    output logic [cmep_pkg::KIND_W-1:0]   event_kind,
    output logic [cmep_pkg::CHAN_W-1:0]   chan,
    output logic [cmep_pkg::FIELD_W-1:0]  first_field,
    output logic [cmep_pkg::FIELD_W-1:0]  second_field,
    output logic [cmep_pkg::TEMPO_W-1:0]  tempo_value,
    output logic [cmep_pkg::OUT_W-1:0]    tick_time,
    output logic [cmep_pkg::OUT_W-1:0]    event_offset,
    output logic [cmep_pkg::LEN_W-1:0]    event_length
);

    assign event_kind   = rec.kind;
    assign chan         = rec.chan;
    assign first_field  = rec.first_field;
    assign second_field = rec.second_field;
    assign tempo_value  = rec.tempo_value;
    assign tick_time    = rec.tick_time;
    assign event_offset = rec.event_offset;
    // span is short, so the low bits of end and start are enough (wraps cleanly)
    assign event_length = rec.end_low - rec.event_offset[cmep_pkg::LEN_W-1:0];

endmodule

[bench/compact_midi_event_parser_test.sv]
// Self-checking testbench for the compact MIDI event parser, with its own event predictor.
`timescale 1ns / 1ps

module compact_midi_event_parser_test;

    localparam logic [2:0] PH_DELTA  = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_DATA1  = 3'd2;
    localparam logic [2:0] PH_DATA2  = 3'd3;
    localparam logic [2:0] PH_META   = 3'd4;
    localparam logic [2:0] PH_TEMPO  = 3'd5;

    localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
    localparam logic [3:0] ST_NOTE_ON    = 4'h9;
    localparam logic [3:0] ST_POLY       = 4'hA;
    localparam logic [3:0] ST_CTRL       = 4'hB;
    localparam logic [3:0] ST_PROG       = 4'hC;
    localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
    localparam logic [3:0] ST_BEND       = 4'hE;
    localparam logic [3:0] ST_SYSTEM     = 4'hF;

    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_END    = 8'h2F;

    localparam logic [6:0] CC_MOD     = 7'd1;
    localparam logic [6:0] CC_BREATH  = 7'd2;
    localparam logic [6:0] CC_LOOPNUM = 7'd6;
    localparam logic [6:0] CC_VOL     = 7'd7;
    localparam logic [6:0] CC_PAN     = 7'd10;
    localparam logic [6:0] CC_EXPR    = 7'd11;
    localparam logic [6:0] CC_LOOPCNT = 7'd38;
    localparam logic [6:0] CC_LOOP    = 7'd99;
    localparam logic [6:0] CC_LIST [8] = '{CC_MOD, CC_BREATH, CC_LOOPNUM, CC_VOL,
                                           CC_PAN, CC_EXPR, CC_LOOPCNT, CC_LOOP};

    localparam int N_DIRECTED   = 35;
    localparam int STAGE_ITEMS  = 530;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 10;

    // Running status, long delta, skipped delta, system status and its reuse, tempo.
    localparam logic [7:0] DIRECTED_BYTES [N_DIRECTED] = '{
        8'h00, 8'h90, 8'h3C, 8'h7F,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h8F, 8'hFF,
        8'h45,
        8'h00, 8'hE5, 8'h7F, 8'h80,
        8'hC3, 8'h80,
        8'hB2, 8'h63, 8'h80,
        8'h40, 8'h85,
        8'hFF, 8'h51, 8'h12, 8'h34, 8'h56, 8'h78,
        8'h00, 8'hF0,
        8'h00, 8'h41, 8'h9A, 8'h40, 8'h00
    };

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                push = 1'b0;
    logic                                full;
    logic [cmep_pkg::BYTE_W-1:0]         byte_in = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    logic [cmep_pkg::KIND_W-1:0]         event_kind;
    logic [cmep_pkg::CHAN_W-1:0]         chan;
    logic [cmep_pkg::FIELD_W-1:0]        first_field;
    logic [cmep_pkg::FIELD_W-1:0]        second_field;
    logic [cmep_pkg::TEMPO_W-1:0]        tempo_value;
    logic [cmep_pkg::OUT_W-1:0]          tick_time;
    logic [cmep_pkg::OUT_W-1:0]          event_offset;
    logic [cmep_pkg::LEN_W-1:0]          event_length;

    // Parser copy
    logic [2:0]   parse_state = PH_DELTA;
    logic [7:0]   last_status = '0;
    bit           no_delta_next = 1'b0;
    logic [27:0]  delta_sum = '0;
    int           delta_len = 0;
    logic [31:0]  tick_now = '0;
    logic [31:0]  byte_count = '0;
    logic [31:0]  event_origin = '0;
    logic [7:0]   active_status = '0;
    logic [6:0]   held_byte = '0;
    bit           held_bit7 = 1'b0;
    logic [23:0]  tempo_sum = '0;
    int           tempo_len = 0;
    bit           stopped = 1'b0;

    cmep_pkg::event_rec_t awaited_events [$];
    cmep_pkg::event_rec_t known_events [int];
    bit                   known_pending = 1'b0;
    cmep_pkg::event_rec_t known_event = '0;
    int                   bytes_taken = 0;
    int                   fail_count = 0;
    int                   idle_cycles = 0;
    int                   send_idle_pct = 15;
    int                   recv_idle_pct = 50;
    bit                   long_delta = 1'b0;

    compact_midi_event_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .byte_in      (byte_in),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .chan         (chan),
        .first_field  (first_field),
        .second_field (second_field),
        .tempo_value  (tempo_value),
        .tick_time    (tick_time),
        .event_offset (event_offset),
        .event_length (event_length)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic cmep_pkg::event_rec_t make_event(input logic [3:0] kind,
                                                        input logic [6:0] f1,
                                                        input logic [6:0] f2,
                                                        input logic [23:0] tempo,
                                                        input logic [31:0] end_pos);
        cmep_pkg::event_rec_t rec;
        rec.kind         = kind;
        rec.chan         = active_status[3:0];
        rec.first_field  = f1;
        rec.second_field = f2;
        rec.tempo_value  = tempo;
        rec.tick_time    = tick_now;
        rec.event_offset = event_origin;
        rec.end_low      = 4'(end_pos - event_origin);
        return rec;
    endfunction

    function automatic void close_event(input logic [31:0] pos);
        event_origin = pos + 32'd1;
        parse_state  = no_delta_next ? PH_STATUS : PH_DELTA;
    endfunction

    function automatic bit classify_controller(input logic [6:0] num, input bit num_high,
                                               input logic [6:0] val, output logic [3:0] kind);
        kind = cmep_pkg::K_UNKNOWN;
        if (num_high)
            return 1'b0;
        case (num)
            CC_MOD:     kind = cmep_pkg::K_MOD;
            CC_BREATH:  kind = cmep_pkg::K_BREATH;
            CC_LOOPNUM: kind = cmep_pkg::K_LOOPNUM;
            CC_VOL:     kind = cmep_pkg::K_VOL;
            CC_PAN:     kind = cmep_pkg::K_PAN;
            CC_EXPR:    kind = cmep_pkg::K_EXPR;
            CC_LOOPCNT: kind = cmep_pkg::K_LOOPCNT;
            CC_LOOP:
            begin
                if (val == 7'd0)
                    kind = cmep_pkg::K_LOOPSTART;
                else if (val == 7'd1)
                    kind = cmep_pkg::K_LOOPEND;
                else
                    return 1'b0;
            end
            default:    return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Advances the parser copy by one byte; made is set when an event results.
    task automatic parse_byte(input logic [7:0] b, output bit made,
                              output cmep_pkg::event_rec_t ev);
        logic [31:0] pos;
        bit          again;
        bit          reused;
        logic [7:0]  st;
        logic [3:0]  hi;
        logic [6:0]  val;
        logic [3:0]  ck;
        made = 1'b0;
        ev   = '0;
        pos  = byte_count;
        if (stopped)
            return;
        do
        begin
            again = 1'b0;
            case (parse_state)
                PH_STATUS:
                begin
                    reused = !b[7];
                    st = reused ? last_status : b;
                    no_delta_next = 1'b0;
                    if (!reused && b != META_STATUS)
                        last_status = b;
                    active_status = st;
                    hi = st[7:4];
                    if (hi == ST_NOTE_OFF || hi == ST_NOTE_ON || hi == ST_CTRL
                        || hi == ST_PROG || hi == ST_BEND)
                    begin
                        parse_state = PH_DATA1;
                        again = reused;
                    end
                    else if (hi == ST_SYSTEM)
                    begin
                        if (st == META_STATUS)
                            parse_state = PH_META;
                        else if (reused)
                        begin
                            // reused byte opens a fresh event as its first delta byte
                            event_origin = pos;
                            parse_state = PH_DELTA;
                            again = 1'b1;
                        end
                        else
                            close_event(pos);
                    end
                    else
                    begin
                        ev = make_event(cmep_pkg::K_UNKNOWN, '0, '0, '0,
                                        reused ? pos : pos + 32'd1);
                        made = 1'b1;
                        stopped = 1'b1;
                    end
                end
                PH_DATA1:
                begin
                    hi = active_status[7:4];
                    if (hi == ST_NOTE_OFF || hi == ST_PROG)
                    begin
                        no_delta_next = b[7];
                        ev = make_event(hi == ST_NOTE_OFF ? cmep_pkg::K_OFF : cmep_pkg::K_PROG,
                                        b[6:0], '0, '0, pos + 32'd1);
                        made = 1'b1;
                        close_event(pos);
                    end
                    else
                    begin
                        held_byte = b[6:0];
                        held_bit7 = b[7];
                        parse_state = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    hi = active_status[7:4];
                    val = b[6:0];
                    no_delta_next = b[7];
                    if (hi == ST_NOTE_ON)
                    begin
                        ev = make_event(val != 7'd0 ? cmep_pkg::K_ON : cmep_pkg::K_OFF,
                                        held_byte, val, '0, pos + 32'd1);
                        made = 1'b1;
                    end
                    else if (hi == ST_CTRL)
                    begin
                        if (classify_controller(held_byte, held_bit7, val, ck))
                        begin
                            ev = make_event(ck, val, '0, '0, pos + 32'd1);
                            made = 1'b1;
                        end
                    end
                    else
                    begin
                        ev = make_event(cmep_pkg::K_BEND, held_byte, val, '0, pos + 32'd1);
                        made = 1'b1;
                    end
                    close_event(pos);
                end
                PH_META:
                begin
                    if (b == META_TEMPO)
                    begin
                        tempo_sum = '0;
                        tempo_len = 0;
                        parse_state = PH_TEMPO;
                    end
                    else
                    begin
                        // non-tempo meta ends the track; only EOT counts the type byte
                        ev = make_event(cmep_pkg::K_END, '0, '0, '0,
                                        b == META_END ? pos + 32'd1 : pos);
                        made = 1'b1;
                        stopped = 1'b1;
                    end
                end
                PH_TEMPO:
                begin
                    tempo_sum = {tempo_sum[15:0], b};
                    tempo_len++;
                    if (tempo_len >= 4)
                    begin
                        tempo_len = 0;
                        ev = make_event(cmep_pkg::K_TEMPO, '0, '0, tempo_sum, pos + 32'd1);
                        made = 1'b1;
                        close_event(pos);
                    end
                end
                default:
                begin
                    delta_sum = {delta_sum[20:0], b[6:0]};
                    delta_len++;
                    if (!b[7] || delta_len >= 4)
                    begin
                        tick_now = tick_now + 32'(delta_sum);
                        delta_sum = '0;
                        delta_len = 0;
                        parse_state = PH_STATUS;
                    end
                end
            endcase
        end
        while (again);
        byte_count = pos + 32'd1;
    endtask

    function automatic logic [7:0] flagged(input int pct, input logic [6:0] v);
        return {($urandom_range(99) < pct), v};
    endfunction

    // Mostly well-formed events, chosen from where the parser copy stands; never halts.
    function automatic logic [7:0] next_random_byte();
        int         r;
        logic [3:0] hi;
        r = $urandom_range(99);
        case (parse_state)
            PH_DELTA:
            begin
                if (delta_len == 0)
                    long_delta = (r < 6);
                if (long_delta)
                    return 8'hFF;
                return flagged(20, 7'($urandom));
            end
            PH_STATUS:
            begin
                if (r < 12)
                    return {1'b0, 7'($urandom)};
                if (r < 20)
                    return META_STATUS;
                if (r < 23)
                    return 8'($urandom_range(8'hFE, 8'hF0));
                r = $urandom_range(9);
                hi = r < 1 ? ST_NOTE_OFF : r < 3 ? ST_NOTE_ON : r < 6 ? ST_CTRL :
                     r < 8 ? ST_PROG : ST_BEND;
                return {hi, 4'($urandom)};
            end
            PH_META:
                return META_TEMPO;
            PH_DATA1:
            begin
                if (active_status[7:4] == ST_CTRL && r < 70)
                    return flagged(5, CC_LIST[$urandom_range(7)]);
                return flagged(20, 7'($urandom));
            end
            PH_DATA2:
            begin
                if (active_status[7:4] == ST_CTRL && held_byte == CC_LOOP && r < 70)
                    return flagged(25, 7'($urandom_range(1)));
                if (r < 8)
                    return flagged(25, 7'd0);
                return flagged(20, 7'($urandom));
            end
            default:
                return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit has_known,
                             input cmep_pkg::event_rec_t want);
        int target;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        target = bytes_taken + 1;
        push <= 1'b1;
        byte_in <= b;
        known_pending <= has_known;
        known_event <= want;
        do
            @(negedge clk);
        while (bytes_taken < target);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (awaited_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        bit                   made;
        cmep_pkg::event_rec_t predicted;
        cmep_pkg::event_rec_t want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                parse_byte(byte_in, made, predicted);
                if (known_pending)
                    awaited_events.push_back(known_event);
                else if (made)
                    awaited_events.push_back(predicted);
                bytes_taken++;
            end
            if (pop && !empty)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("event popped with none expected: kind %0d offset 0x%0h",
                           event_kind, event_offset);
                    fail_count++;
                end
                else
                begin
                    want = awaited_events.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(event_kind));
                    check_field("chan", 32'(want.chan), 32'(chan));
                    check_field("first_field", 32'(want.first_field), 32'(first_field));
                    check_field("second_field", 32'(want.second_field), 32'(second_field));
                    check_field("tempo_value", 32'(want.tempo_value), 32'(tempo_value));
                    check_field("tick_time", want.tick_time, tick_time);
                    check_field("event_offset", want.event_offset, event_offset);
                    check_field("event_length", 32'(want.end_low), 32'(event_length));
                end
            end
        end
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** compact_midi_event_parser: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [7:0] halt_byte;
        int         stage;
        known_events[3]  = '{cmep_pkg::K_ON, 4'h0, 7'h3C, 7'h7F, 24'h0,
                             32'h0, 32'd0, 4'd4};
        known_events[9]  = '{cmep_pkg::K_OFF, 4'hF, 7'h7F, 7'h00, 24'h0,
                             32'h0FFFFFFF, 32'd4, 4'd6};
        known_events[10] = '{cmep_pkg::K_OFF, 4'hF, 7'h45, 7'h00, 24'h0,
                             32'h0FFFFFFF, 32'd10, 4'd1};
        known_events[14] = '{cmep_pkg::K_BEND, 4'h5, 7'h7F, 7'h00, 24'h0,
                             32'h0FFFFFFF, 32'd11, 4'd4};
        known_events[16] = '{cmep_pkg::K_PROG, 4'h3, 7'h00, 7'h00, 24'h0,
                             32'h0FFFFFFF, 32'd15, 4'd2};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (known_events.exists(i))
                send_byte(DIRECTED_BYTES[i], 1'b1, known_events[i]);
            else
                send_byte(DIRECTED_BYTES[i], 1'b0, '0);
        end

        for (stage = 0; stage < 3; stage++)
        begin
            send_idle_pct = (stage == 0) ? 15 : (stage == 1) ? 50 : 0;
            recv_idle_pct = (stage == 0) ? 50 : (stage == 1) ? 15 : 0;
            repeat (STAGE_ITEMS) send_byte(next_random_byte(), 1'b0, '0);
            wait_for_drain();
        end

        // close the open event, then stop the parser one way or another
        while (parse_state != PH_STATUS)
            send_byte(next_random_byte(), 1'b0, '0);
        case ($urandom_range(3))
            0:
            begin
                send_byte(META_STATUS, 1'b0, '0);
                send_byte(META_END, 1'b0, '0);
            end
            1:
            begin
                send_byte(META_STATUS, 1'b0, '0);
                do
                    halt_byte = 8'($urandom);
                while (halt_byte == META_TEMPO);
                send_byte(halt_byte, 1'b0, '0);
            end
            2:
                send_byte({ST_POLY, 4'($urandom)}, 1'b0, '0);
            default:
                send_byte({ST_CHAN_PRESS, 4'($urandom)}, 1'b0, '0);
        endcase
        // everything after the stop must be dropped
        repeat (8) send_byte(8'($urandom), 1'b0, '0);
        wait_for_drain();

        if (fail_count == 0)
            $display("** compact_midi_event_parser: PASSED **");
        else
            $display("** compact_midi_event_parser: FAILED **");
        $finish;
    end

endmodule
